// ===== sv/im2col_address_generator_macros.svh =====
// Assertion macros shared by the im2col address generator checker.
`ifndef IM2COL_ADDRESS_GENERATOR_MACROS_SVH
`define IM2COL_ADDRESS_GENERATOR_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define I2C_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("im2col check failed");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define I2C_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("im2col check failed");

// Next-cycle check that also runs while reset is asserted.
`define I2C_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("im2col check failed");

`endif

// ===== sv/i2c_pkg.sv =====
// Types, constants and register indexes of the im2col address generator.
package i2c_pkg;

    localparam int DILATION_Y         = 1;
    localparam int DILATION_X         = 1;
    localparam int PIXEL_STRIDE_BYTES = 64;
    localparam int MAX_TAPS           = 64;

    localparam int OFF_W      = 30;  // byte offset width
    localparam int COORD_W    = 18;  // signed source row / column
    localparam int MAC_B_W    = 14;  // second operand of the shared unit
    localparam int POS_W      = 12;
    localparam int KDIM_W     = 4;
    localparam int PAD_W      = 3;
    localparam int DIM_W      = 13;
    localparam int TAP_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int TCOL_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [OFF_W-1:0]   STEP_X  = OFF_W'(DILATION_X * PIXEL_STRIDE_BYTES);
    localparam logic [MAC_B_W-1:0] ROW_MUL = MAC_B_W'(DILATION_Y * PIXEL_STRIDE_BYTES);
    localparam logic [MAC_B_W-1:0] PIX_MUL = MAC_B_W'(PIXEL_STRIDE_BYTES);
    localparam logic [COUNT_W-1:0] TAP_LIMIT = COUNT_W'(MAX_TAPS);

    localparam logic [KDIM_W-1:0] KDIM_MAX = KDIM_W'(8);

    // reset values of the configuration registers
    localparam logic [KDIM_W-1:0] KH_RESET = KDIM_W'(3);
    localparam logic [KDIM_W-1:0] KW_RESET = KDIM_W'(3);
    localparam logic [KDIM_W-1:0] SY_RESET = KDIM_W'(1);
    localparam logic [KDIM_W-1:0] SX_RESET = KDIM_W'(1);
    localparam logic [DIM_W-1:0]  IH_RESET = DIM_W'(1);
    localparam logic [DIM_W-1:0]  IW_RESET = DIM_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KROWS         = 3'd0,
        CFG_KCOLS         = 3'd1,
        CFG_STRIDE_Y      = 3'd2,
        CFG_STRIDE_X      = 3'd3,
        CFG_PAD_TOP       = 3'd4,
        CFG_PAD_LEFT      = 3'd5,
        CFG_INPUT_HEIGHT  = 3'd6,
        CFG_INPUT_WIDTH   = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [POS_W-1:0] out_y;
        logic [POS_W-1:0] out_x;
    } t_in_item;

    typedef struct packed {
        logic [OFF_W-1:0] src_offset;
        logic             zero_fill;
        logic [TAP_W-1:0] tap_index;
        logic             last_tap;
    } t_out_item;

    // operands of the shared multiply-add unit: a * b + c, modulo 2^OFF_W
    typedef struct packed {
        logic [OFF_W-1:0]   a;
        logic [MAC_B_W-1:0] b;
        logic [OFF_W-1:0]   c;
    } t_mac_req;

endpackage

// ===== sv/im2col_address_generator.sv =====
// im2col address generator: each accepted request (out_y, out_x) yields one result per
// kernel tap in row-major order, carrying the byte offset of the source pixel or a
// zero-fill flag for taps in padding. A request first runs setup steps on the single
// shared multiply-add unit (source row, source column, row pitch, pixel index, byte
// offset), then issues one tap per cycle while the sink does not stall, then returns
// to idle before the next request can be taken; the input is not ready until then.
// Configuration writes take effect at once and must only be issued while the block is
// idle with no result outstanding.
module im2col_address_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [i2c_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [i2c_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  i2c_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output i2c_pkg::t_out_item                 o_out_item
);
    import i2c_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Y,
        ST_X,
        ST_ROW,
        ST_PIX,
        ST_OFF,
        ST_TAP
    } t_state;

    t_state r_state, n_state;

    logic [KDIM_W-1:0] r_cfg_kh, r_cfg_kw, r_cfg_sy, r_cfg_sx;
    logic [PAD_W-1:0]  r_cfg_pt, r_cfg_pl;
    logic [DIM_W-1:0]  r_cfg_ih, r_cfg_iw;

    logic [POS_W-1:0]   r_y, n_y, r_x, n_x;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COORD_W-1:0] r_ry, n_ry, r_cx, n_cx, r_cx0, n_cx0;
    logic [OFF_W-1:0]   r_row_step, n_row_step, r_off, n_off, r_row_off, n_row_off;
    logic [TCOL_W-1:0]  r_tap_col, n_tap_col;
    logic [TAP_W-1:0]   r_tap_idx, n_tap_idx;

    logic [KDIM_W-1:0]  kh_c, kw_c;
    logic [COUNT_W-1:0] total;
    logic               in_image, last, row_end;

    t_mac_req           mac_req;
    logic [OFF_W-1:0]   mac_res;

    logic               out_load, out_free;
    t_out_item          out_item;

    i2c_mac u_mac (
        .i_req (mac_req),
        .o_res (mac_res)
    );

    i2c_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_item  (out_item),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // kernel dimensions of zero act as one, above eight as eight
    always_comb begin
        kh_c = r_cfg_kh;
        kw_c = r_cfg_kw;
        if (r_cfg_kh == '0) kh_c = KDIM_W'(1);
        else if (r_cfg_kh > KDIM_MAX) kh_c = KDIM_MAX;
        if (r_cfg_kw == '0) kw_c = KDIM_W'(1);
        else if (r_cfg_kw > KDIM_MAX) kw_c = KDIM_MAX;
    end

    assign total   = COUNT_W'(kh_c) * COUNT_W'(kw_c);
    assign o_in_ready = (r_state == ST_IDLE);

    assign in_image = !r_ry[COORD_W-1] && !r_cx[COORD_W-1] &&
                      (r_ry[COORD_W-2:0] < (COORD_W-1)'(r_cfg_ih)) &&
                      (r_cx[COORD_W-2:0] < (COORD_W-1)'(r_cfg_iw));
    assign last    = (COUNT_W'(r_tap_idx) + COUNT_W'(1)) == r_count;
    assign row_end = (KDIM_W'(r_tap_col) == (kw_c - KDIM_W'(1)));

    always_comb begin
        n_state    = r_state;
        n_y        = r_y;
        n_x        = r_x;
        n_count    = r_count;
        n_ry       = r_ry;
        n_cx       = r_cx;
        n_cx0      = r_cx0;
        n_row_step = r_row_step;
        n_off      = r_off;
        n_row_off  = r_row_off;
        n_tap_col  = r_tap_col;
        n_tap_idx  = r_tap_idx;
        mac_req    = '0;
        out_load   = 1'b0;
        out_item   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_y     = i_in_item.out_y;
                    n_x     = i_in_item.out_x;
                    n_count = (total > TAP_LIMIT) ? TAP_LIMIT : total;
                    n_state = ST_Y;
                end
            end
            ST_Y: begin
                mac_req.a = OFF_W'(r_y);
                mac_req.b = MAC_B_W'(r_cfg_sy);
                mac_req.c = OFF_W'(0) - OFF_W'(r_cfg_pt);
                n_ry      = mac_res[COORD_W-1:0];
                n_state   = ST_X;
            end
            ST_X: begin
                mac_req.a = OFF_W'(r_x);
                mac_req.b = MAC_B_W'(r_cfg_sx);
                mac_req.c = OFF_W'(0) - OFF_W'(r_cfg_pl);
                n_cx      = mac_res[COORD_W-1:0];
                n_cx0     = mac_res[COORD_W-1:0];
                n_state   = ST_ROW;
            end
            ST_ROW: begin
                // byte distance between successive kernel rows
                mac_req.a  = OFF_W'(r_cfg_iw);
                mac_req.b  = ROW_MUL;
                n_row_step = mac_res;
                n_state    = ST_PIX;
            end
            ST_PIX: begin
                // signed coordinates wrap consistently modulo 2^OFF_W
                mac_req.a = {{(OFF_W-COORD_W){r_ry[COORD_W-1]}}, r_ry};
                mac_req.b = MAC_B_W'(r_cfg_iw);
                mac_req.c = {{(OFF_W-COORD_W){r_cx[COORD_W-1]}}, r_cx};
                n_off     = mac_res;
                n_state   = ST_OFF;
            end
            ST_OFF: begin
                mac_req.a = r_off;
                mac_req.b = PIX_MUL;
                n_off     = mac_res;
                n_row_off = mac_res;
                n_tap_col = '0;
                n_tap_idx = '0;
                n_state   = ST_TAP;
            end
            ST_TAP: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_item.src_offset = in_image ? r_off : '0;
                    out_item.zero_fill  = !in_image;
                    out_item.tap_index  = r_tap_idx;
                    out_item.last_tap   = last;
                    n_tap_idx           = r_tap_idx + TAP_W'(1);
                    if (last) begin
                        n_state = ST_IDLE;
                    end else if (row_end) begin
                        n_tap_col = '0;
                        n_ry      = r_ry + COORD_W'(DILATION_Y);
                        n_cx      = r_cx0;
                        n_row_off = r_row_off + r_row_step;
                        n_off     = r_row_off + r_row_step;
                    end else begin
                        n_tap_col = r_tap_col + TCOL_W'(1);
                        n_cx      = r_cx + COORD_W'(DILATION_X);
                        n_off     = r_off + STEP_X;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cfg_kh <= KH_RESET;
            r_cfg_kw <= KW_RESET;
            r_cfg_sy <= SY_RESET;
            r_cfg_sx <= SX_RESET;
            r_cfg_pt <= '0;
            r_cfg_pl <= '0;
            r_cfg_ih <= IH_RESET;
            r_cfg_iw <= IW_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_KROWS:         r_cfg_kh <= i_cfg_data[KDIM_W-1:0];
                    CFG_KCOLS:         r_cfg_kw <= i_cfg_data[KDIM_W-1:0];
                    CFG_STRIDE_Y:      r_cfg_sy <= i_cfg_data[KDIM_W-1:0];
                    CFG_STRIDE_X:      r_cfg_sx <= i_cfg_data[KDIM_W-1:0];
                    CFG_PAD_TOP:       r_cfg_pt <= i_cfg_data[PAD_W-1:0];
                    CFG_PAD_LEFT:      r_cfg_pl <= i_cfg_data[PAD_W-1:0];
                    CFG_INPUT_HEIGHT:  r_cfg_ih <= i_cfg_data[DIM_W-1:0];
                    CFG_INPUT_WIDTH:   r_cfg_iw <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
        r_y        <= n_y;
        r_x        <= n_x;
        r_count    <= n_count;
        r_ry       <= n_ry;
        r_cx       <= n_cx;
        r_cx0      <= n_cx0;
        r_row_step <= n_row_step;
        r_off      <= n_off;
        r_row_off  <= n_row_off;
        r_tap_col  <= n_tap_col;
        r_tap_idx  <= n_tap_idx;
    end

endmodule

// ===== sv/i2c_mac.sv =====
// Shared multiply-add unit used by the setup steps of the sequencer.
module i2c_mac (
    input  i2c_pkg::t_mac_req             i_req,
    output logic [i2c_pkg::OFF_W-1:0]     o_res
);
    import i2c_pkg::*;

    logic [OFF_W+MAC_B_W-1:0] prod;

    assign prod  = (OFF_W+MAC_B_W)'(i_req.a) * (OFF_W+MAC_B_W)'(i_req.b);
    assign o_res = prod[OFF_W-1:0] + i_req.c;

endmodule

// ===== sv/i2c_out_reg.sv =====
// Output register that holds one result request until the sink takes it.
module i2c_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2c_pkg::t_out_item  i_item,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output i2c_pkg::t_out_item  o_item
);
    import i2c_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (o_free && i_load) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== sv/im2col_address_generator_checker.sv =====
// Port-level checker for the im2col address generator, bound to the top level.
`include "im2col_address_generator_macros.svh"

module im2col_address_generator_sva (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [i2c_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [i2c_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  i2c_pkg::t_in_item                  i_in_item,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  i2c_pkg::t_out_item                 o_out_item
);
    import i2c_pkg::*;

    // an accepted request always needs setup cycles before the next one
    `I2C_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a stalled result holds
    `I2C_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // padding taps carry no offset
    `I2C_ASSERT_SAME(a_fill_zero, i_clk, i_rst_n, o_out_valid && o_out_item.zero_fill, o_out_item.src_offset == '0)

    // reset empties the output register and leaves the input ready
    `I2C_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind im2col_address_generator im2col_address_generator_sva u_checker (.*);
